// ----- design/rcgt_pkg.sv -----
// Shared types and constants for the radio channel gesture trigger.
package rcgt_pkg;

	// Widths of the configuration port and of the register fields.
	localparam int unsigned CFG_INDEX_WIDTH = 3;
	localparam int unsigned CFG_DATA_WIDTH  = 16;
	localparam int unsigned LEVEL_WIDTH     = 8;
	localparam int unsigned TICKS_WIDTH     = 16;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_LOW_LEVEL   = 3'd0,
		REG_HIGH_LEVEL  = 3'd1,
		REG_HOLD_TICKS  = 3'd2,
		REG_MIN_RELEASE = 3'd3,
		REG_MAX_RELEASE = 3'd4
	} reg_index_t;

	// Register values after reset.
	localparam logic [LEVEL_WIDTH-1:0] LOW_LEVEL_RESET   = 8'd120;
	localparam logic [LEVEL_WIDTH-1:0] HIGH_LEVEL_RESET  = 8'd130;
	localparam logic [TICKS_WIDTH-1:0] HOLD_TICKS_RESET  = 16'd10000;
	localparam logic [TICKS_WIDTH-1:0] MIN_RELEASE_RESET = 16'd3000;
	localparam logic [TICKS_WIDTH-1:0] MAX_RELEASE_RESET = 16'd10000;

	// Item opcodes.
	typedef enum logic {
		OP_TICK   = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

	// Gesture phases.
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_LOW   = 2'd1,
		PH_ARMED = 2'd2,
		PH_HIGH  = 2'd3
	} phase_t;

	// Current register set, as seen by the gesture logic.
	typedef struct packed {
		logic [LEVEL_WIDTH-1:0] low_level;
		logic [LEVEL_WIDTH-1:0] high_level;
		logic [TICKS_WIDTH-1:0] hold_ticks;
		logic [TICKS_WIDTH-1:0] min_release_ticks;
		logic [TICKS_WIDTH-1:0] max_release_ticks;
	} cfg_t;

	// Result flags of one item.
	typedef struct packed {
		logic   fire_pulse;
		logic   fire_channel;
		logic   sequence_end;
		phase_t gesture_phase;
	} result_t;

endpackage

// ----- design/rcgt_if.sv -----
// Handshake channel interfaces for input items, results and register writes.
interface rcgt_item_if;
	logic                                valid;
	logic                                ready;
	logic                                opcode;
	logic [rcgt_pkg::LEVEL_WIDTH-1:0]    channel_value;

	modport source(output valid, output opcode, output channel_value, input ready);
	modport sink(input valid, input opcode, input channel_value, output ready);
endinterface

interface rcgt_result_if;
	logic       valid;
	logic       ready;
	logic       fire_pulse;
	logic       fire_channel;
	logic       sequence_end;
	logic [1:0] gesture_phase;

	modport source(output valid, output fire_pulse, output fire_channel,
		output sequence_end, output gesture_phase, input ready);
	modport sink(input valid, input fire_pulse, input fire_channel,
		input sequence_end, input gesture_phase, output ready);
endinterface

interface rcgt_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [rcgt_pkg::CFG_INDEX_WIDTH-1:0]   index;
	logic [rcgt_pkg::CFG_DATA_WIDTH-1:0]    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- design/rcgt_cfg_regs.sv -----
// Configuration register file for the gesture trigger.
module rcgt_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	rcgt_cfg_if.sink        cfg,
	output rcgt_pkg::cfg_t  regs
);

	rcgt_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.low_level         <= rcgt_pkg::LOW_LEVEL_RESET;
			regs_q.high_level        <= rcgt_pkg::HIGH_LEVEL_RESET;
			regs_q.hold_ticks        <= rcgt_pkg::HOLD_TICKS_RESET;
			regs_q.min_release_ticks <= rcgt_pkg::MIN_RELEASE_RESET;
			regs_q.max_release_ticks <= rcgt_pkg::MAX_RELEASE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (rcgt_pkg::reg_index_t'(cfg.index))
				rcgt_pkg::REG_LOW_LEVEL: begin
					regs_q.low_level <= cfg.data[rcgt_pkg::LEVEL_WIDTH-1:0];
				end
				rcgt_pkg::REG_HIGH_LEVEL: begin
					regs_q.high_level <= cfg.data[rcgt_pkg::LEVEL_WIDTH-1:0];
				end
				rcgt_pkg::REG_HOLD_TICKS: begin
					regs_q.hold_ticks <= cfg.data[rcgt_pkg::TICKS_WIDTH-1:0];
				end
				rcgt_pkg::REG_MIN_RELEASE: begin
					regs_q.min_release_ticks <= cfg.data[rcgt_pkg::TICKS_WIDTH-1:0];
				end
				rcgt_pkg::REG_MAX_RELEASE: begin
					regs_q.max_release_ticks <= cfg.data[rcgt_pkg::TICKS_WIDTH-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- design/rcgt_step.sv -----
// Next-state and result logic for one tick or sample item.
module rcgt_step #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  rcgt_pkg::cfg_t             regs,
	input  logic                       opcode,
	input  logic [rcgt_pkg::LEVEL_WIDTH-1:0] channel_value,
	input  rcgt_pkg::phase_t           phase,
	input  logic [COUNT_WIDTH-1:0]     elapsed,
	input  logic                       next_output,
	output rcgt_pkg::phase_t           phase_next,
	output logic [COUNT_WIDTH-1:0]     elapsed_next,
	output logic                       next_output_next,
	output rcgt_pkg::result_t          result
);

	// Compares run at the wider of the counter and the register width.
	localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > rcgt_pkg::TICKS_WIDTH) ?
		COUNT_WIDTH : rcgt_pkg::TICKS_WIDTH;

	logic                 is_low;
	logic                 is_high;
	logic [CMP_WIDTH-1:0] cnt_ext;
	logic [CMP_WIDTH-1:0] hold_ext;
	logic [CMP_WIDTH-1:0] min_ext;
	logic [CMP_WIDTH-1:0] max_ext;
	logic                 in_window;
	logic                 past_hold;

	assign is_low    = channel_value < regs.low_level;
	assign is_high   = channel_value > regs.high_level;
	assign cnt_ext   = CMP_WIDTH'(elapsed);
	assign hold_ext  = CMP_WIDTH'(regs.hold_ticks);
	assign min_ext   = CMP_WIDTH'(regs.min_release_ticks);
	assign max_ext   = CMP_WIDTH'(regs.max_release_ticks);
	assign in_window = (cnt_ext >= min_ext) && (cnt_ext <= max_ext);
	assign past_hold = cnt_ext > hold_ext;

	// The phase checks are evaluated in order on one sample, so a release
	// that ends on a low sample falls through to the idle check and re-arms.
	always_comb begin
		rcgt_pkg::phase_t ph;
		ph               = phase;
		elapsed_next     = elapsed;
		next_output_next = next_output;
		result           = '0;

		if (rcgt_pkg::opcode_t'(opcode) == rcgt_pkg::OP_TICK) begin
			if (elapsed != {COUNT_WIDTH{1'b1}}) begin
				elapsed_next = elapsed + COUNT_WIDTH'(1);
			end
		end else begin
			if (ph == rcgt_pkg::PH_HIGH && is_low) begin
				if (in_window) begin
					result.fire_pulse   = 1'b1;
					result.fire_channel = next_output;
					result.sequence_end = next_output;
					next_output_next    = ~next_output;
				end
				ph = rcgt_pkg::PH_IDLE;
			end
			if (ph == rcgt_pkg::PH_ARMED && is_high) begin
				ph           = rcgt_pkg::PH_HIGH;
				elapsed_next = '0;
			end
			if (ph == rcgt_pkg::PH_LOW && past_hold) begin
				ph = rcgt_pkg::PH_ARMED;
			end
			if (ph == rcgt_pkg::PH_IDLE && is_low) begin
				ph           = rcgt_pkg::PH_LOW;
				elapsed_next = '0;
			end
		end

		phase_next           = ph;
		result.gesture_phase = ph;
	end

endmodule

// ----- design/rc_channel_gesture_trigger_core.sv -----
// Top level of the radio channel gesture trigger.
//
// Items arrive on the in channel: opcode 0 is a timer tick, opcode 1 a new
// channel sample. Every accepted item produces exactly one result on the out
// channel, carrying the fire flags and the gesture phase after that item.
// Registers are written through the cfg channel, which is always ready; a
// write should only be issued while no request is in flight.
//
// An accepted request is held in an input register, evaluated against the
// gesture state, and lands in the result register, from which it is offered
// to the receiver. One request can be accepted every cycle while the receiver
// keeps taking results; the state update is the only loop.
//
// Reset clears the phase to idle, the elapsed counter to zero, selects the
// first output and loads the register defaults. When the receiver stalls, the
// result register holds its value and one more request may wait in the input
// register; after that in.ready drops until the result is taken.
module rc_channel_gesture_trigger_core #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	rcgt_item_if.sink     in,
	rcgt_result_if.source out,
	rcgt_cfg_if.sink      cfg
);

	rcgt_pkg::cfg_t                    regs;

	logic                              valid_s1;
	logic                              opcode_s1;
	logic [rcgt_pkg::LEVEL_WIDTH-1:0]  value_s1;

	rcgt_pkg::phase_t                  phase_q;
	logic [COUNT_WIDTH-1:0]            elapsed_q;
	logic                              next_output_q;

	rcgt_pkg::phase_t                  phase_next;
	logic [COUNT_WIDTH-1:0]            elapsed_next;
	logic                              next_output_next;
	rcgt_pkg::result_t                 result;

	logic                              out_valid_q;
	rcgt_pkg::result_t                 result_q;

	logic                              advance;

	rcgt_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	rcgt_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.regs             (regs),
		.opcode           (opcode_s1),
		.channel_value    (value_s1),
		.phase            (phase_q),
		.elapsed          (elapsed_q),
		.next_output      (next_output_q),
		.phase_next       (phase_next),
		.elapsed_next     (elapsed_next),
		.next_output_next (next_output_next),
		.result           (result)
	);

	// The held request moves on whenever the result register is free or
	// is being emptied in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out.ready);
	assign in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			opcode_s1 <= in.opcode;
			value_s1  <= in.channel_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= rcgt_pkg::PH_IDLE;
			elapsed_q     <= '0;
			next_output_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				phase_q       <= phase_next;
				elapsed_q     <= elapsed_next;
				next_output_q <= next_output_next;
				out_valid_q   <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out.valid         = out_valid_q;
	assign out.fire_pulse    = result_q.fire_pulse;
	assign out.fire_channel  = result_q.fire_channel;
	assign out.sequence_end  = result_q.sequence_end;
	assign out.gesture_phase = result_q.gesture_phase;

endmodule

// ----- design/rcgt_checker.sv -----
// Port-level checker for the gesture trigger, bound to the top level.
module rcgt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       fire_pulse,
	input logic       fire_channel,
	input logic       sequence_end,
	input logic [1:0] gesture_phase
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fire_pulse) &&
		$stable(fire_channel) && $stable(sequence_end) && $stable(gesture_phase))
		else $error("result changed while stalled");

	// A firing ends on a low sample, which always re-arms into the low phase.
	a_fire_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fire_pulse |-> gesture_phase == 2'd1)
		else $error("firing without re-arm into low phase");

	// End of sequence only comes with a firing of the second output.
	a_seq_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sequence_end |-> fire_pulse && fire_channel)
		else $error("sequence end without second output firing");

	// The output select is only reported with a firing.
	a_chan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fire_pulse |-> !fire_channel && !sequence_end)
		else $error("output select set without firing");

endmodule

bind rc_channel_gesture_trigger_core rcgt_checker u_rcgt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out.valid),
	.out_ready     (out.ready),
	.fire_pulse    (out.fire_pulse),
	.fire_channel  (out.fire_channel),
	.sequence_end  (out.sequence_end),
	.gesture_phase (out.gesture_phase)
);

// ----- tb/tb_rc_channel_gesture_trigger_core.sv -----
// Self-checking testbench for the radio channel gesture trigger core.
`timescale 1ns / 1ps

module tb_rc_channel_gesture_trigger_core;

	localparam int unsigned COUNT_WIDTH = 16;
	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 4;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SEND_IDLE_PCT = 23;
	localparam int RECV_IDLE_PCT = 56;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int ITEMS_PER_ROUND = 64;
	localparam int LONG_COUNT_TICKS = 258;
	localparam int MAX_PRINTED = 40;
	localparam logic [rcgt_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_FIRST = 3'd5;

	logic clk;
	logic arst_n;

	rcgt_item_if   item_ch();
	rcgt_result_if res_ch();
	rcgt_cfg_if    cfg_ch();

	rc_channel_gesture_trigger_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in(item_ch),
		.out(res_ch),
		.cfg(cfg_ch)
	);

	// Gesture state and register copy kept by the testbench.
	rcgt_pkg::cfg_t         gest_cfg;
	rcgt_pkg::phase_t       gest_phase;
	logic [COUNT_WIDTH-1:0] gest_elapsed;
	logic                   gest_next;

	rcgt_pkg::result_t expected_results[$];

	int send_idle_pct;
	int recv_idle_pct;
	bit recv_hold;
	event hold_off_kick;

	int cycle_count;
	int mismatch_count;
	int items_sent;
	int results_seen;
	int fires_seen;
	int wraps_seen;
	int config_count;
	int input_stall_cycles;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (item_ch.valid === 1'b1 && item_ch.ready === 1'b0)
			input_stall_cycles <= input_stall_cycles + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles with %0d results outstanding.",
			cycle_count, expected_results.size());
		$display("rc_channel_gesture_trigger_core regression: fail");
		$finish;
	end

	// The receiver takes results at random, except during a long hold-off.
	always @(posedge clk) begin
		res_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		forever begin
			@(hold_off_kick);
			recv_hold <= 1'b1;
			repeat (LONG_HOLD_CYCLES) @(posedge clk);
			recv_hold <= 1'b0;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [1:0] want,
			input logic [1:0] got);
		if (got !== want)
			report_mismatch($sformatf("%s expected %0d, got %0d (result %0d)",
				name, want, got, results_seen));
	endtask

	always @(posedge clk) begin : check_results
		rcgt_pkg::result_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result arrived with no request waiting");
			end else begin
				want = expected_results.pop_front();
				check_field("fire_pulse", 2'(want.fire_pulse), 2'(res_ch.fire_pulse));
				check_field("fire_channel", 2'(want.fire_channel),
					2'(res_ch.fire_channel));
				check_field("sequence_end", 2'(want.sequence_end),
					2'(res_ch.sequence_end));
				check_field("gesture_phase", want.gesture_phase, res_ch.gesture_phase);
			end
			results_seen++;
			if (res_ch.fire_pulse === 1'b1)
				fires_seen++;
			if (res_ch.sequence_end === 1'b1)
				wraps_seen++;
		end
	end

	function automatic void reset_gesture_state();
		gest_cfg.low_level = rcgt_pkg::LOW_LEVEL_RESET;
		gest_cfg.high_level = rcgt_pkg::HIGH_LEVEL_RESET;
		gest_cfg.hold_ticks = rcgt_pkg::HOLD_TICKS_RESET;
		gest_cfg.min_release_ticks = rcgt_pkg::MIN_RELEASE_RESET;
		gest_cfg.max_release_ticks = rcgt_pkg::MAX_RELEASE_RESET;
		gest_phase = rcgt_pkg::PH_IDLE;
		gest_elapsed = '0;
		gest_next = 1'b0;
	endfunction

	// Advances the gesture state by one request and returns the result it causes.
	// The phase checks run in a fixed order, so one sample can pass through several.
	function automatic rcgt_pkg::result_t next_gesture_result(input rcgt_pkg::opcode_t op,
			input logic [rcgt_pkg::LEVEL_WIDTH-1:0] value);
		rcgt_pkg::result_t r;
		logic is_low;
		logic is_high;
		r = '0;
		if (op == rcgt_pkg::OP_TICK) begin
			if (gest_elapsed != {COUNT_WIDTH{1'b1}})
				gest_elapsed = gest_elapsed + 1'b1;
		end else begin
			is_low = value < gest_cfg.low_level;
			is_high = value > gest_cfg.high_level;
			if (gest_phase == rcgt_pkg::PH_HIGH && is_low) begin
				if (gest_elapsed >= gest_cfg.min_release_ticks &&
						gest_elapsed <= gest_cfg.max_release_ticks) begin
					r.fire_pulse = 1'b1;
					r.fire_channel = gest_next;
					r.sequence_end = gest_next;
					gest_next = !gest_next;
				end
				gest_phase = rcgt_pkg::PH_IDLE;
			end
			if (gest_phase == rcgt_pkg::PH_ARMED && is_high) begin
				gest_phase = rcgt_pkg::PH_HIGH;
				gest_elapsed = '0;
			end
			if (gest_phase == rcgt_pkg::PH_LOW && gest_elapsed > gest_cfg.hold_ticks)
				gest_phase = rcgt_pkg::PH_ARMED;
			if (gest_phase == rcgt_pkg::PH_IDLE && is_low) begin
				gest_elapsed = '0;
				gest_phase = rcgt_pkg::PH_LOW;
			end
		end
		r.gesture_phase = gest_phase;
		return r;
	endfunction

	task automatic send_item(input rcgt_pkg::opcode_t op,
			input logic [rcgt_pkg::LEVEL_WIDTH-1:0] value);
		if ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= op;
		item_ch.channel_value <= value;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		expected_results.push_back(next_gesture_result(op, value));
		items_sent++;
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_item(rcgt_pkg::OP_TICK, 8'($urandom_range(255)));
	endtask

	task automatic send_noise(input int count);
		repeat (count)
			send_item(rcgt_pkg::opcode_t'($urandom_range(1)), 8'($urandom_range(255)));
	endtask

	// Every request yields a result, so an empty store means the core is idle.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [rcgt_pkg::CFG_INDEX_WIDTH-1:0] index,
			input logic [rcgt_pkg::CFG_DATA_WIDTH-1:0] data, input bit last);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		case (index)
			rcgt_pkg::REG_LOW_LEVEL:
				gest_cfg.low_level = data[rcgt_pkg::LEVEL_WIDTH-1:0];
			rcgt_pkg::REG_HIGH_LEVEL:
				gest_cfg.high_level = data[rcgt_pkg::LEVEL_WIDTH-1:0];
			rcgt_pkg::REG_HOLD_TICKS:  gest_cfg.hold_ticks = data;
			rcgt_pkg::REG_MIN_RELEASE: gest_cfg.min_release_ticks = data;
			rcgt_pkg::REG_MAX_RELEASE: gest_cfg.max_release_ticks = data;
			default: ;
		endcase
		if (last)
			cfg_ch.valid <= 1'b0;
	endtask

	// Level registers get random upper bits, which the core must drop.
	task automatic set_config(input logic [rcgt_pkg::LEVEL_WIDTH-1:0] low_lvl,
			input logic [rcgt_pkg::LEVEL_WIDTH-1:0] high_lvl,
			input logic [rcgt_pkg::TICKS_WIDTH-1:0] hold,
			input logic [rcgt_pkg::TICKS_WIDTH-1:0] min_rel,
			input logic [rcgt_pkg::TICKS_WIDTH-1:0] max_rel);
		logic [7:0] pad_lo;
		logic [7:0] pad_hi;
		pad_lo = 8'($urandom_range(255));
		pad_hi = 8'($urandom_range(255));
		wait_idle();
		cfg_write(rcgt_pkg::REG_LOW_LEVEL, {pad_lo, low_lvl}, 1'b0);
		cfg_write(rcgt_pkg::REG_HIGH_LEVEL, {pad_hi, high_lvl}, 1'b0);
		cfg_write(rcgt_pkg::REG_HOLD_TICKS, hold, 1'b0);
		cfg_write(rcgt_pkg::REG_MIN_RELEASE, min_rel, 1'b0);
		cfg_write(rcgt_pkg::REG_MAX_RELEASE, max_rel, 1'b1);
		config_count++;
	endtask

	task automatic send_gesture(input int hold_len, input int release_len);
		send_item(rcgt_pkg::OP_SAMPLE, 8'h00);
		send_ticks(hold_len);
		send_item(rcgt_pkg::OP_SAMPLE, 8'hFF);
		send_item(rcgt_pkg::OP_SAMPLE, 8'hFF);
		send_ticks(release_len);
		send_item(rcgt_pkg::OP_SAMPLE, 8'h00);
	endtask

	function automatic logic [rcgt_pkg::LEVEL_WIDTH-1:0] pick_low();
		return 8'($urandom_range(gest_cfg.low_level - 1, 0));
	endfunction

	function automatic logic [rcgt_pkg::LEVEL_WIDTH-1:0] pick_high();
		return 8'($urandom_range(255, gest_cfg.high_level + 1));
	endfunction

	// A value that is neither low nor high, where the levels leave room for one.
	function automatic logic [rcgt_pkg::LEVEL_WIDTH-1:0] pick_mid();
		if (gest_cfg.low_level <= gest_cfg.high_level)
			return 8'($urandom_range(gest_cfg.high_level, gest_cfg.low_level));
		return pick_high();
	endfunction

	task automatic send_random_gesture();
		int hold_len;
		int release_len;
		if (gest_cfg.low_level == 0 || gest_cfg.high_level == 8'hFF) begin
			send_noise($urandom_range(6, 1));
			return;
		end
		hold_len = $urandom_range(gest_cfg.hold_ticks + 2, 0);
		release_len = $urandom_range(gest_cfg.max_release_ticks + 2, 0);
		send_item(rcgt_pkg::OP_SAMPLE, pick_low());
		send_ticks(hold_len);
		if ($urandom_range(1))
			send_item(rcgt_pkg::OP_SAMPLE, pick_mid());
		send_item(rcgt_pkg::OP_SAMPLE, pick_high());
		send_item(rcgt_pkg::OP_SAMPLE, pick_high());
		repeat (release_len) begin
			if ($urandom_range(5) == 0)
				send_item(rcgt_pkg::OP_SAMPLE, pick_mid());
			send_item(rcgt_pkg::OP_TICK, 8'($urandom_range(255)));
		end
		send_item(rcgt_pkg::OP_SAMPLE, pick_low());
	endtask

	task automatic set_random_config();
		int lo;
		int hi;
		int mn;
		int mx;
		if ($urandom_range(3) == 0) begin
			lo = $urandom_range(255);
			hi = $urandom_range(255);
		end else begin
			lo = $urandom_range(180, 1);
			hi = $urandom_range(254, lo - 1);
		end
		mn = $urandom_range(5, 0);
		if (mn > 0 && $urandom_range(5) == 0)
			mx = mn - 1;
		else
			mx = $urandom_range(mn + 6, mn);
		set_config(8'(lo), 8'(hi), 16'($urandom_range(6, 0)), 16'(mn), 16'(mx));
	endtask

	// Writes to unused indexes must leave the reset levels in place.
	task automatic test_spare_registers();
		int i;
		wait_idle();
		for (i = int'(REG_SPARE_FIRST); i < (1 << rcgt_pkg::CFG_INDEX_WIDTH); i++)
			cfg_write(i[rcgt_pkg::CFG_INDEX_WIDTH-1:0], 16'($urandom_range(16'hFFFF)),
				i == (1 << rcgt_pkg::CFG_INDEX_WIDTH) - 1);
	endtask

	task automatic test_default_levels();
		send_item(rcgt_pkg::OP_SAMPLE, rcgt_pkg::LOW_LEVEL_RESET);
		send_item(rcgt_pkg::OP_SAMPLE, rcgt_pkg::HIGH_LEVEL_RESET);
		send_item(rcgt_pkg::OP_SAMPLE, rcgt_pkg::HIGH_LEVEL_RESET + 1'b1);
		send_item(rcgt_pkg::OP_SAMPLE, 8'hFF);
		send_item(rcgt_pkg::OP_SAMPLE, rcgt_pkg::LOW_LEVEL_RESET - 1'b1);
		send_ticks(1);
		send_item(rcgt_pkg::OP_SAMPLE, 8'h00);
	endtask

	// Both outputs in turn at the window edges, among rejected releases and holds.
	task automatic test_fire_sequence();
		set_config(8'd100, 8'd200, 16'd1, 16'd1, 16'd2);
		send_gesture(2, 1);
		send_gesture(2, 2);
		send_gesture(2, 0);
		send_gesture(2, 3);
		send_gesture(2, 1);
		send_gesture(1, 1);
	endtask

	task automatic test_level_extremes();
		set_config(8'd0, 8'd255, 16'd0, 16'd0, 16'd0);
		send_item(rcgt_pkg::OP_SAMPLE, 8'h00);
		send_item(rcgt_pkg::OP_SAMPLE, 8'hFF);
		// With the levels crossed, one sample counts as both low and high.
		set_config(8'd255, 8'd0, 16'd0, 16'd0, 16'd0);
		send_item(rcgt_pkg::OP_SAMPLE, 8'h80);
		send_item(rcgt_pkg::OP_SAMPLE, 8'h80);
		send_ticks(1);
		send_item(rcgt_pkg::OP_SAMPLE, 8'h80);
		send_item(rcgt_pkg::OP_SAMPLE, 8'h80);
		send_item(rcgt_pkg::OP_SAMPLE, 8'h80);
		send_item(rcgt_pkg::OP_SAMPLE, 8'hFF);
	endtask

	// A hold time past eight bits: the low phase arms only once the count
	// is strictly above it, and a release at the top of the window fires.
	task automatic test_long_count();
		int keep_send;
		int keep_recv;
		keep_send = send_idle_pct;
		keep_recv = recv_idle_pct;
		set_config(8'd100, 8'd200, 16'(LONG_COUNT_TICKS), 16'd0, 16'd3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_item(rcgt_pkg::OP_SAMPLE, 8'h00);
		send_ticks(LONG_COUNT_TICKS);
		send_item(rcgt_pkg::OP_SAMPLE, 8'd150);
		send_ticks(1);
		send_item(rcgt_pkg::OP_SAMPLE, 8'd150);
		send_item(rcgt_pkg::OP_SAMPLE, 8'hFF);
		send_ticks(3);
		send_item(rcgt_pkg::OP_SAMPLE, 8'h00);
		send_idle_pct = keep_send;
		recv_idle_pct = keep_recv;
	endtask

	task automatic test_random_gestures();
		int mode;
		int round_end;
		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = SEND_IDLE_PCT;
					recv_idle_pct = RECV_IDLE_PCT;
				end
				1: begin
					send_idle_pct = RECV_IDLE_PCT;
					recv_idle_pct = SEND_IDLE_PCT;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (4) begin
				set_random_config();
				round_end = items_sent + ITEMS_PER_ROUND;
				while (items_sent < round_end) begin
					if ($urandom_range(4) == 0)
						send_noise($urandom_range(6, 1));
					else
						send_random_gesture();
				end
			end
		end
	endtask

	// The receiver stops taking results while requests keep coming, so the
	// core has to fill up and push back on its input.
	task automatic test_input_backpressure();
		int keep_send;
		keep_send = send_idle_pct;
		set_config(8'd100, 8'd200, 16'd2, 16'd0, 16'd4);
		send_idle_pct = 0;
		-> hold_off_kick;
		repeat (6) send_random_gesture();
		send_idle_pct = keep_send;
	endtask

	initial begin
		item_ch.valid <= 1'b0;
		item_ch.opcode <= rcgt_pkg::OP_TICK;
		item_ch.channel_value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= rcgt_pkg::REG_LOW_LEVEL;
		cfg_ch.data <= '0;
		arst_n <= 1'b0;
		mismatch_count = 0;
		items_sent = 0;
		results_seen = 0;
		fires_seen = 0;
		wraps_seen = 0;
		config_count = 0;
		send_idle_pct = SEND_IDLE_PCT;
		recv_idle_pct = RECV_IDLE_PCT;
		reset_gesture_state();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_spare_registers();
		test_default_levels();
		test_fire_sequence();
		test_level_extremes();
		test_long_count();
		test_random_gestures();
		test_input_backpressure();

		wait_idle();
		$display("Covered %0d requests and %0d results: %0d firings, %0d sequence wraps.",
			items_sent, results_seen, fires_seen, wraps_seen);
		$display("Used %0d register settings; input held back for %0d cycles.",
			config_count, input_stall_cycles);
		if (mismatch_count == 0)
			$display("rc_channel_gesture_trigger_core regression: pass");
		else
			$display("rc_channel_gesture_trigger_core regression: fail");
		$finish;
	end

endmodule
